FILE: design/ddcf_pkg.sv
// Shared types, codes and frame helpers for the dual DAC chain command framer.
// No dependencies; every other design file imports this package.
`default_nettype none

package ddcf_pkg;

  // DAC resolution; frames carry the code left-justified in 16 bits
  localparam int CODE_BITS = 12;

  localparam int MV_W    = 16;
  localparam int REF_W   = 13;
  localparam int GAIN_W  = 2;
  localparam int FS_W    = REF_W + GAIN_W;
  localparam int PROD_W  = MV_W + CODE_BITS + 1;
  localparam int DIV_CNT_W = $clog2(CODE_BITS);
  localparam int FRAME_W = 24;
  localparam int WORD_W  = 48;
  localparam int BITS_W  = 6;

  localparam logic [CODE_BITS-1:0] MAX_CODE = '1;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_REF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd1;
  localparam logic [REF_W-1:0]  REF_RESET  = 13'd2500;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 2'd1;

  // command queue
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  // actions
  localparam logic [2:0] ACT_WRITE        = 3'd0;
  localparam logic [2:0] ACT_UPDATE       = 3'd1;
  localparam logic [2:0] ACT_WRITE_UPDATE = 3'd2;
  localparam logic [2:0] ACT_SET_MV       = 3'd3;
  localparam logic [2:0] ACT_SET_BOTH     = 3'd4;
  localparam logic [2:0] ACT_POWER        = 3'd5;
  localparam logic [2:0] ACT_RESET        = 3'd6;
  localparam logic [2:0] ACT_CHAIN        = 3'd7;

  // device select
  localparam logic [1:0] DEV_NEAR    = 2'd0;
  localparam logic [1:0] DEV_FAR     = 2'd1;
  localparam logic [1:0] DEV_BOTH    = 2'd2;
  localparam logic [1:0] DEV_INVALID = 2'd3;

  // channel nibbles
  localparam logic [3:0] CH_A    = 4'h1;
  localparam logic [3:0] CH_B    = 4'h8;
  localparam logic [3:0] CH_BOTH = 4'h9;

  // DAC command nibbles
  localparam logic [3:0] OP_WRITE        = 4'h1;
  localparam logic [3:0] OP_UPDATE       = 4'h2;
  localparam logic [3:0] OP_WRITE_UPDATE = 4'h3;
  localparam logic [3:0] OP_POWER        = 4'h4;
  localparam logic [3:0] OP_RESET        = 4'h6;
  localparam logic [3:0] OP_CHAIN        = 4'h8;
  localparam logic [3:0] OP_NOP          = 4'hF;

  localparam logic [FRAME_W-1:0] NOP_FRAME      = {OP_NOP, 20'h00000};
  localparam logic [FRAME_W-1:0] CHAIN_ON_FRAME = {OP_CHAIN, 20'h00001};
  localparam logic [FRAME_W-1:0] RESET_FRAME    = {OP_RESET, 20'h00001};

  localparam logic [BITS_W-1:0] BITS_NONE  = 6'd0;
  localparam logic [BITS_W-1:0] BITS_SHORT = 6'd24;
  localparam logic [BITS_W-1:0] BITS_LONG  = 6'd48;

  // result index within one command
  localparam logic [1:0] STEP_FIRST  = 2'd0;
  localparam logic [1:0] STEP_SECOND = 2'd1;

  typedef struct packed {
    logic                 err;
    logic [2:0]           act;
    logic [1:0]           dev;
    logic [3:0]           ch;
    logic [CODE_BITS-1:0] code;
    logic [MV_W-1:0]      mv;
    logic [MV_W-1:0]      mvb;
    logic [1:0]           pa;
    logic [1:0]           pb;
  } job_t;

  function automatic logic [FRAME_W-1:0] dac_frame(input logic [3:0] op,
                                                   input logic [3:0] ch,
                                                   input logic [CODE_BITS-1:0] code);
    logic [15:0] c;
    c = 16'(code) << (16 - CODE_BITS);
    return {op, ch, c};
  endfunction

  // far frame goes out first; an unselected device gets a no-op
  function automatic logic [WORD_W-1:0] chain_word(input logic [1:0] dev,
                                                   input logic [FRAME_W-1:0] frame);
    logic [FRAME_W-1:0] near_f;
    logic [FRAME_W-1:0] far_f;
    near_f = (dev == DEV_FAR)  ? NOP_FRAME : frame;
    far_f  = (dev == DEV_NEAR) ? NOP_FRAME : frame;
    return {far_f, near_f};
  endfunction

  function automatic logic [FRAME_W-1:0] power_frame(input logic [1:0] pa,
                                                     input logic [1:0] pb);
    return {OP_POWER, 12'h000, pb, 4'hF, pa};
  endfunction

endpackage

`default_nettype wire

FILE: design/ddcf_front.sv
// Front end: takes commands and checks device and channel before queueing.
// Depends on ddcf_pkg.
`default_nettype none

module ddcf_front
  import ddcf_pkg::*;
(
  input  wire logic                 start,
  input  wire logic                 q_full,
  input  wire logic [2:0]           action,
  input  wire logic [1:0]           device_select,
  input  wire logic [3:0]           channel,
  input  wire logic [CODE_BITS-1:0] code,
  input  wire logic [MV_W-1:0]      millivolts,
  input  wire logic [MV_W-1:0]      millivolts_b,
  input  wire logic [1:0]           power_mode_a,
  input  wire logic [1:0]           power_mode_b,
  output      logic                 push,
  output      job_t                 job
);

  logic ch_ok;
  logic needs_ch;

  assign ch_ok    = (channel == CH_A) || (channel == CH_B) || (channel == CH_BOTH);
  assign needs_ch = (action == ACT_WRITE) || (action == ACT_UPDATE) ||
                    (action == ACT_WRITE_UPDATE) || (action == ACT_SET_MV);

  assign push = start && !q_full;

  always_comb begin
    job.err  = (action != ACT_CHAIN) &&
               ((device_select == DEV_INVALID) || (needs_ch && !ch_ok));
    job.act  = action;
    job.dev  = device_select;
    job.ch   = channel;
    job.code = code;
    job.mv   = millivolts;
    job.mvb  = millivolts_b;
    job.pa   = power_mode_a;
    job.pb   = power_mode_b;
  end

endmodule

`default_nettype wire

FILE: design/ddcf_queue.sv
// Short command queue between front end and sequencer.
// Depends on ddcf_pkg.
`default_nettype none

module ddcf_queue
  import ddcf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_data,
  input  wire logic pop,
  output      logic full,
  output      logic empty,
  output      job_t head
);

  job_t               slots [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full  = (count == Q_CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: design/ddcf_back.sv
// Back end: walks each queued command through its transfers, converting
// millivolts with a multiply and a restoring divider. Depends on ddcf_pkg.
`default_nettype none

module ddcf_back
  import ddcf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire job_t              q_head,
  input  wire logic [REF_W-1:0]  reference_millivolts,
  input  wire logic [GAIN_W-1:0] output_gain,
  output      logic              pop,
  output      logic              strobe,
  output      logic [WORD_W-1:0] shift_word,
  output      logic [BITS_W-1:0] bit_count,
  output      logic              status,
  output      logic              last
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_MUL      = 5'b00100,
    S_DIV      = 5'b01000,
    S_EMIT     = 5'b10000
  } state_t;

  state_t                 state;
  job_t                   job;
  logic [1:0]             step;
  logic [FS_W-1:0]        fs_r;
  logic [FS_W-1:0]        rem;
  logic [CODE_BITS-1:0]   quo;
  logic [DIV_CNT_W-1:0]   cnt;
  logic                   fs_zero;
  logic                   sat;

  logic                   need_conv;
  logic [MV_W-1:0]        mv_sel;
  logic [FS_W-1:0]        fs;
  logic [PROD_W-1:0]      prod;
  logic [FS_W:0]          shifted;
  logic [FS_W:0]          diff;
  logic                   q_bit;
  logic [FS_W-1:0]        rem_next;
  logic [CODE_BITS-1:0]   conv_code;

  logic [WORD_W-1:0]      res_word;
  logic [BITS_W-1:0]      res_bits;
  logic                   res_status;
  logic                   res_last;

  assign pop = (state == S_IDLE) && !q_empty;

  assign need_conv = !job.err &&
                     (((job.act == ACT_SET_MV) && (step == STEP_FIRST)) ||
                      ((job.act == ACT_SET_BOTH) &&
                       ((step == STEP_FIRST) || (step == STEP_SECOND))));

  // full scale and rounded numerator mv*MAX + fs/2
  assign mv_sel = (step == STEP_SECOND) ? job.mvb : job.mv;
  assign fs     = FS_W'(reference_millivolts) * FS_W'(output_gain);
  assign prod   = PROD_W'(mv_sel) * PROD_W'(MAX_CODE) + PROD_W'(fs[FS_W-1:1]);

  // one quotient bit per cycle; remainder stays below fs
  assign shifted  = {rem, quo[CODE_BITS-1]};
  assign diff     = shifted - {1'b0, fs_r};
  assign q_bit    = (shifted >= {1'b0, fs_r});
  assign rem_next = q_bit ? diff[FS_W-1:0] : shifted[FS_W-1:0];

  assign conv_code = fs_zero ? '0 : (sat ? MAX_CODE : quo);

  always_comb begin
    res_word   = '0;
    res_bits   = BITS_LONG;
    res_status = 1'b0;
    res_last   = 1'b1;
    if (job.err) begin
      res_bits   = BITS_NONE;
      res_status = 1'b1;
    end else begin
      case (job.act)
        ACT_WRITE:        res_word = chain_word(job.dev, dac_frame(OP_WRITE, job.ch, job.code));
        ACT_UPDATE:       res_word = chain_word(job.dev, dac_frame(OP_UPDATE, job.ch, '0));
        ACT_WRITE_UPDATE: begin
          res_word = chain_word(job.dev, dac_frame(OP_WRITE_UPDATE, job.ch, job.code));
        end
        ACT_SET_MV: begin
          res_word = chain_word(job.dev, dac_frame(OP_WRITE_UPDATE, job.ch, conv_code));
        end
        ACT_SET_BOTH: begin
          if (step == STEP_FIRST) begin
            res_word = chain_word(job.dev, dac_frame(OP_WRITE, CH_A, conv_code));
            res_last = 1'b0;
          end else if (step == STEP_SECOND) begin
            res_word = chain_word(job.dev, dac_frame(OP_WRITE, CH_B, conv_code));
            res_last = 1'b0;
          end else begin
            res_word = chain_word(job.dev, dac_frame(OP_UPDATE, CH_BOTH, '0));
          end
        end
        ACT_POWER:        res_word = chain_word(job.dev, power_frame(job.pa, job.pb));
        ACT_RESET: begin
          if (step == STEP_FIRST) begin
            res_word = chain_word(job.dev, RESET_FRAME);
            res_last = (job.dev == DEV_FAR);
          end else begin
            res_word = WORD_W'(CHAIN_ON_FRAME);
            res_bits = BITS_SHORT;
          end
        end
        ACT_CHAIN: begin
          if (step == STEP_FIRST) begin
            res_word = WORD_W'(CHAIN_ON_FRAME);
            res_bits = BITS_SHORT;
            res_last = 1'b0;
          end else begin
            res_word = chain_word(DEV_BOTH, NOP_FRAME);
          end
        end
        default: begin
          res_bits   = BITS_NONE;
          res_status = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            job   <= q_head;
            step  <= STEP_FIRST;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          state <= need_conv ? S_MUL : S_EMIT;
        end
        S_MUL: begin
          fs_r    <= fs;
          fs_zero <= (fs == '0);
          sat     <= (mv_sel >= MV_W'(fs));
          rem     <= prod[FS_W+CODE_BITS-1:CODE_BITS];
          quo     <= prod[CODE_BITS-1:0];
          cnt     <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          rem <= rem_next;
          quo <= {quo[CODE_BITS-2:0], q_bit};
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_W'(CODE_BITS - 1)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          strobe     <= 1'b1;
          shift_word <= res_word;
          bit_count  <= res_bits;
          status     <= res_status;
          last       <= res_last;
          if (res_last) begin
            state <= S_IDLE;
          end else begin
            step  <= step + 1'b1;
            state <= S_DISPATCH;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/dual_dac_chain_command_framer.sv
// Top level of the dual DAC chain command framer: config registers, front end,
// command queue and transfer sequencer. Depends on ddcf_pkg and the ddcf_* modules.
//
// Usage:
//   Commands enter on start while busy is low; busy is high only when the
//   four-entry command queue is full. Each command yields one to three
//   transfer results, each shown for one cycle with strobe high and last
//   marking the final one of the command. The receiver cannot stall.
//   Registers are written over cfg_valid/cfg_ready (always ready) with
//   cfg_index 0 = reference millivolts, 1 = output gain.
// Sequence:
//   A taken command is queued, then popped by the sequencer, which goes
//   from dispatch straight to emit for raw-code actions, and through one
//   multiply state and a 12-step restoring divider for millivolt actions.
//   Each further result passes back through dispatch, and the divider too
//   if it needs a conversion. The sequencer sets the rate; set-both is longest.
// Reset:
//   Queue emptied, sequencer idle, reference 2500 mV, gain 1.
`default_nettype none

module dual_dac_chain_command_framer
  import ddcf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output      logic                 busy,
  input  wire logic [2:0]           action,
  input  wire logic [1:0]           device_select,
  input  wire logic [3:0]           channel,
  input  wire logic [CODE_BITS-1:0] code,
  input  wire logic [MV_W-1:0]      millivolts,
  input  wire logic [MV_W-1:0]      millivolts_b,
  input  wire logic [1:0]           power_mode_a,
  input  wire logic [1:0]           power_mode_b,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REF_W-1:0]     cfg_data,
  output      logic                 strobe,
  output      logic [WORD_W-1:0]    shift_word,
  output      logic [BITS_W-1:0]    bit_count,
  output      logic                 status,
  output      logic                 last
);

  logic              reference_millivolts;
  logic [REF_W-1:0]  ref_mv;
  logic [GAIN_W-1:0] output_gain;
  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  job_t              job;
  job_t              q_head;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;
  // reference_millivolts is a single-bit write select; ref_mv holds the reference register
  assign reference_millivolts = cfg_valid && (cfg_index == REG_REF);

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_mv      <= REF_RESET;
      output_gain <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (reference_millivolts) begin
        ref_mv <= cfg_data;
      end else if (cfg_index == REG_GAIN) begin
        output_gain <= cfg_data[GAIN_W-1:0];
      end
    end
  end

  ddcf_front u_front (
    .start         (start),
    .q_full        (q_full),
    .action        (action),
    .device_select (device_select),
    .channel       (channel),
    .code          (code),
    .millivolts    (millivolts),
    .millivolts_b  (millivolts_b),
    .power_mode_a  (power_mode_a),
    .power_mode_b  (power_mode_b),
    .push          (push),
    .job           (job)
  );

  ddcf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (job),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  ddcf_back u_back (
    .clk                  (clk),
    .rst                  (rst),
    .q_empty              (q_empty),
    .q_head               (q_head),
    .reference_millivolts (ref_mv),
    .output_gain          (output_gain),
    .pop                  (pop),
    .strobe               (strobe),
    .shift_word           (shift_word),
    .bit_count            (bit_count),
    .status               (status),
    .last                 (last)
  );

endmodule

`default_nettype wire

FILE: design/ddcf_checker.sv
// Port-level checks for the dual DAC chain command framer, bound to the top.
// Depends on ddcf_pkg.
`default_nettype none

module ddcf_checker
  import ddcf_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              busy,
  input wire logic              strobe,
  input wire logic [WORD_W-1:0] shift_word,
  input wire logic [BITS_W-1:0] bit_count,
  input wire logic              status,
  input wire logic              last
);

  // an error result stands alone and sends nothing
  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    strobe && status |-> last && (bit_count == BITS_NONE) && (shift_word == '0))
    else $error("error result not empty or not last");

  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    strobe && !status |-> (bit_count == BITS_SHORT) || (bit_count == BITS_LONG))
    else $error("bad transfer length");

  a_short_upper: assert property (@(posedge clk) disable iff (rst)
    strobe && (bit_count == BITS_SHORT) |-> (shift_word[WORD_W-1:FRAME_W] == '0))
    else $error("24-bit transfer has upper bits set");

  // the sequencer never shows results of one command back to back
  a_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> !strobe)
    else $error("back-to-back results within one command");

  a_reset: assert property (@(posedge clk)
    rst |=> !strobe && !busy)
    else $error("outputs not quiet after reset");

endmodule

bind dual_dac_chain_command_framer ddcf_checker u_ddcf_checker (
  .clk        (clk),
  .rst        (rst),
  .busy       (busy),
  .strobe     (strobe),
  .shift_word (shift_word),
  .bit_count  (bit_count),
  .status     (status),
  .last       (last)
);

`default_nettype wire
